[hdl/pfb_pkg.sv]
package pfb_pkg;

   localparam int DISPLAY_WIDTH  = 240;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = 8;

   localparam int COL_W     = 8;
   localparam int ROW_W     = 6;
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int ADDR_W    = PAGE_W + COL_W;
   localparam int MEM_DEPTH = PAGE_COUNT * (2 ** COL_W);

   localparam int HALF_FIRST  = DISPLAY_WIDTH / 2;
   localparam int HALF_SECOND = DISPLAY_WIDTH - DISPLAY_WIDTH / 2;

   localparam logic [2:0] KIND_HLINE = 3'd0;
   localparam logic [2:0] KIND_VLINE = 3'd1;
   localparam logic [2:0] KIND_GLYPH = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   typedef logic [255:0][7:0] mod_table_type;

   function automatic mod_table_type build_col_table();
      mod_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(i % DISPLAY_WIDTH);
      end
      return t;
   endfunction

   function automatic mod_table_type build_row_table();
      mod_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(i % DISPLAY_HEIGHT);
      end
      return t;
   endfunction

   localparam mod_table_type COL_MOD_TABLE = build_col_table();
   localparam mod_table_type ROW_MOD_TABLE = build_row_table();

   function automatic logic [7:0] reverse_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7 - k] = v[k];
      end
      return r;
   endfunction

endpackage

[hdl/pfb_req_if.sv]
interface pfb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] col;
   logic [7:0] row;
   logic [7:0] length;
   logic [7:0] glyph_byte;
   logic       half;
   logic       rotated;
   logic [2:0] page_index;
   logic [6:0] column_offset;

   modport source (
      output valid, kind, col, row, length, glyph_byte, half, rotated, page_index,
             column_offset,
      input  ready
   );

   modport sink (
      input  valid, kind, col, row, length, glyph_byte, half, rotated, page_index,
             column_offset,
      output ready
   );
endinterface

[hdl/pfb_rsp_if.sv]
interface pfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       is_read;

   modport source (
      output valid, read_byte, is_read,
      input  ready
   );

   modport sink (
      input  valid, read_byte, is_read,
      output ready
   );
endinterface

[hdl/pfb_ram.sv]
// single-port-write / single-port-read RAM, registered read data
module pfb_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/page_framebuffer_draw_engine_core.sv]
// Page frame store with a small draw engine for a monochrome panel.
//
// req_if (sink): one command item per handshake (valid & ready). Kinds are
//   horizontal line, vertical line, glyph column OR, byte read and clear.
// rsp_if (source): exactly one result item per command, in order. A read
//   returns the byte in read_byte with is_read set; every other kind gives
//   zero with is_read clear.
// The block takes one command at a time; ready is high only between commands.
// States from accept to result valid (the store has registered read data and
// every pixel write is a read-modify-write of one byte in S_STEP and S_WB):
//   read               S_RD, S_RDW, S_FIN
//   read out of range  S_FIN
//   horizontal line    S_STEP, S_WB per column drawn, S_STEP, S_FIN
//   vertical line      S_STEP, S_WB per row drawn, S_STEP, S_FIN
//   glyph column       S_STEP, S_WB per page (one or two touched), S_STEP, S_FIN
//   clear              S_CLR over MEM_DEPTH (2048), one entry per cycle; S_FIN
// Reset starts the same clear sweep with ready low; no result is
// produced for it. A stalled receiver holds the result in the output register;
// the next finished result waits until that register is taken.
module page_framebuffer_draw_engine_core (
   input  logic       clock,
   input  logic       reset,
   pfb_req_if.sink    req_if,
   pfb_rsp_if.source  rsp_if
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STEP = 3'd1;   // issue read of next byte to modify
   localparam logic [2:0] S_WB   = 3'd2;   // read data back, write modified byte
   localparam logic [2:0] S_RD   = 3'd3;   // issue panel read
   localparam logic [2:0] S_RDW  = 3'd4;   // panel read data back
   localparam logic [2:0] S_CLR  = 3'd5;   // clear sweep
   localparam logic [2:0] S_FIN  = 3'd6;   // hand result to output register

   localparam logic [8:0] WIDTH_9  = 9'(pfb_pkg::DISPLAY_WIDTH);
   localparam logic [8:0] HEIGHT_9 = 9'(pfb_pkg::DISPLAY_HEIGHT);

   // control state
   logic [2:0]                  state_ff, state_in;
   logic                        boot_ff, boot_in;
   logic [pfb_pkg::ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // per-command working registers
   logic [2:0]                  kind_ff, kind_in;
   logic [pfb_pkg::COL_W-1:0]   col_ff, col_in;
   logic [pfb_pkg::PAGE_W-1:0]  page_ff, page_in;
   logic [7:0]                  mask_ff, mask_in;
   logic [7:0]                  spill_ff, spill_in;
   logic [8:0]                  cur_ff, cur_in;
   logic [8:0]                  stop_ff, stop_in;
   logic                        rev_ff, rev_in;
   logic [7:0]                  res_byte_ff, res_byte_in;
   logic                        res_read_ff, res_read_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_is_read_ff, rsp_is_read_in;

   // memory port
   logic                        mem_wr_en, mem_rd_en;
   logic [pfb_pkg::ADDR_W-1:0]  mem_wr_addr;
   logic [7:0]                  mem_wr_data, mem_rd_data;

   // decode of the incoming command
   logic [pfb_pkg::COL_W-1:0]   col_m;
   logic [pfb_pkg::ROW_W-1:0]   row_m;
   logic [8:0]                  hsum, hstop, vsum, vstop;
   logic [15:0]                 glyph_wide;
   logic                        use_second, in_range;
   logic [7:0]                  half_lo, half_w, half_end, rd_col;

   // per-step address and OR mask
   logic [pfb_pkg::ADDR_W-1:0]  step_addr;
   logic [7:0]                  step_mask;
   logic                        step_more, out_free;

   assign col_m = pfb_pkg::COL_MOD_TABLE[req_if.col];
   assign row_m = pfb_pkg::ROW_MOD_TABLE[req_if.row][pfb_pkg::ROW_W-1:0];

   // line ends without wrap, clipped at the panel edge
   assign hsum  = {1'b0, col_m} + {1'b0, req_if.length};
   assign hstop = (hsum > WIDTH_9) ? WIDTH_9 : hsum;
   assign vsum  = {3'b000, row_m} + {1'b0, req_if.length};
   assign vstop = (vsum > HEIGHT_9) ? HEIGHT_9 : vsum;

   // glyph shifted across the page boundary: low byte and spill
   assign glyph_wide = {8'h00, req_if.glyph_byte} << row_m[2:0];

   // rotated read uses the opposite half, mirrored column and page
   assign use_second = req_if.half ^ req_if.rotated;
   assign half_lo    = use_second ? 8'(pfb_pkg::HALF_FIRST) : 8'd0;
   assign half_w     = use_second ? 8'(pfb_pkg::HALF_SECOND) : 8'(pfb_pkg::HALF_FIRST);
   assign half_end   = use_second ? 8'(pfb_pkg::DISPLAY_WIDTH - 1)
                                  : 8'(pfb_pkg::HALF_FIRST - 1);
   assign in_range   = {1'b0, req_if.column_offset} < half_w;
   assign rd_col     = req_if.rotated ? (half_end - {1'b0, req_if.column_offset})
                                      : (half_lo + {1'b0, req_if.column_offset});

   always_comb begin
      case (kind_ff)
         pfb_pkg::KIND_HLINE: begin
            step_addr = {page_ff, cur_ff[pfb_pkg::COL_W-1:0]};
            step_mask = mask_ff;
         end
         pfb_pkg::KIND_VLINE: begin
            step_addr = {cur_ff[5:3], col_ff};
            step_mask = 8'd1 << cur_ff[2:0];
         end
         pfb_pkg::KIND_GLYPH: begin
            if (cur_ff[0]) begin
               step_addr = {page_ff + 3'd1, col_ff};
               step_mask = spill_ff;
            end else begin
               step_addr = {page_ff, col_ff};
               step_mask = mask_ff;
            end
         end
         default: begin
            // panel read address
            step_addr = {page_ff, col_ff};
            step_mask = 8'h00;
         end
      endcase
   end

   assign step_more = cur_ff < stop_ff;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in       = state_ff;
      boot_in        = boot_ff;
      clr_cnt_in     = clr_cnt_ff;
      kind_in        = kind_ff;
      col_in         = col_ff;
      page_in        = page_ff;
      mask_in        = mask_ff;
      spill_in       = spill_ff;
      cur_in         = cur_ff;
      stop_in        = stop_ff;
      rev_in         = rev_ff;
      res_byte_in    = res_byte_ff;
      res_read_in    = res_read_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_is_read_in = rsp_is_read_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;

      mem_wr_en   = 1'b0;
      mem_wr_addr = step_addr;
      mem_wr_data = mem_rd_data | step_mask;
      mem_rd_en   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in     = req_if.kind;
               res_byte_in = 8'h00;
               res_read_in = 1'b0;
               case (req_if.kind)
                  pfb_pkg::KIND_HLINE: begin
                     page_in  = row_m[5:3];
                     mask_in  = 8'd1 << row_m[2:0];
                     cur_in   = {1'b0, col_m};
                     stop_in  = hstop;
                     state_in = S_STEP;
                  end
                  pfb_pkg::KIND_VLINE: begin
                     col_in   = col_m;
                     cur_in   = {3'b000, row_m};
                     stop_in  = vstop;
                     state_in = S_STEP;
                  end
                  pfb_pkg::KIND_GLYPH: begin
                     col_in   = col_m;
                     page_in  = row_m[5:3];
                     mask_in  = glyph_wide[7:0];
                     spill_in = glyph_wide[15:8];
                     cur_in   = 9'd0;
                     // spill below the last page is dropped
                     stop_in  = (row_m[2:0] != 3'd0 && row_m[5:3] != 3'd7) ? 9'd2 : 9'd1;
                     state_in = S_STEP;
                  end
                  pfb_pkg::KIND_READ: begin
                     page_in     = req_if.rotated ? ~req_if.page_index : req_if.page_index;
                     col_in      = rd_col;
                     rev_in      = req_if.rotated;
                     res_read_in = 1'b1;
                     state_in    = in_range ? S_RD : S_FIN;
                  end
                  pfb_pkg::KIND_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLR;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_STEP: begin
            if (step_more) begin
               mem_rd_en = 1'b1;
               state_in  = S_WB;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WB: begin
            // the next read is issued in the following cycle, so it sees this write
            mem_wr_en = 1'b1;
            cur_in    = cur_ff + 9'd1;
            state_in  = S_STEP;
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_RDW;
         end
         S_RDW: begin
            res_byte_in = rev_ff ? pfb_pkg::reverse_byte(mem_rd_data) : mem_rd_data;
            state_in    = S_FIN;
         end
         S_CLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = 8'h00;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = res_byte_ff;
               rsp_is_read_in = res_read_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         boot_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      col_ff         <= col_in;
      page_ff        <= page_in;
      mask_ff        <= mask_in;
      spill_ff       <= spill_in;
      cur_ff         <= cur_in;
      stop_ff        <= stop_in;
      rev_ff         <= rev_in;
      res_byte_ff    <= res_byte_in;
      res_read_ff    <= res_read_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

   pfb_ram #(
      .WIDTH (8),
      .DEPTH (pfb_pkg::MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (step_addr),
      .rd_data (mem_rd_data)
   );

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_byte = rsp_byte_ff;
   assign rsp_if.is_read   = rsp_is_read_ff;

endmodule

[hdl/pfb_checker.sv]
module pfb_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_is_read
);

   // result item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after an accepted item");

   // store clear after reset keeps the input closed
   a_boot_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("ready high before the reset clear finished");

   // only reads carry data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_read |-> rsp_read_byte == 8'h00)
      else $error("non-read result with nonzero data");

endmodule

bind page_framebuffer_draw_engine_core pfb_props u_pfb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_byte (rsp_if.read_byte),
   .rsp_is_read   (rsp_if.is_read)
);

[verif/pfb_checker.sv]
module pfb_checker
   import pfb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pfb_req_if   req_mon,
   pfb_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending,
   output int   lit_reads
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       is_read;
   } panel_out_t;

   // shadow of the panel image, page by column
   logic [7:0] frame_copy [PAGE_COUNT][DISPLAY_WIDTH];
   panel_out_t due_results [$];

   function automatic logic [7:0] mirror_byte(input logic [7:0] v);
      return {<<{v}};
   endfunction

   // Applies one command to the shadow image and returns the panel output.
   task automatic draw_or_read(
      input  logic [2:0] kind,
      input  logic [7:0] col,
      input  logic [7:0] row,
      input  logic [7:0] length,
      input  logic [7:0] glyph_byte,
      input  logic       half,
      input  logic       rotated,
      input  logic [2:0] page_index,
      input  logic [6:0] column_offset,
      output panel_out_t res
   );
      int c, r, stop, lo, hi;
      logic       other_half;
      logic [15:0] spread;
      c = int'(col) % DISPLAY_WIDTH;
      r = int'(row) % DISPLAY_HEIGHT;
      res = '0;
      case (kind)
         KIND_HLINE: begin
            stop = c + int'(length);
            if (stop > DISPLAY_WIDTH) stop = DISPLAY_WIDTH;
            for (int i = c; i < stop; i++) frame_copy[r / 8][i] |= 8'(1 << (r % 8));
         end
         KIND_VLINE: begin
            stop = r + int'(length);
            if (stop > DISPLAY_HEIGHT) stop = DISPLAY_HEIGHT;
            for (int i = r; i < stop; i++) frame_copy[i / 8][c] |= 8'(1 << (i % 8));
         end
         KIND_GLYPH: begin
            spread = 16'(glyph_byte) << (r % 8);
            frame_copy[r / 8][c] |= spread[7:0];
            // spill below the last page falls off the panel
            if (r / 8 < PAGE_COUNT - 1) frame_copy[r / 8 + 1][c] |= spread[15:8];
         end
         KIND_READ: begin
            other_half = rotated ? ~half : half;
            lo = other_half ? DISPLAY_WIDTH / 2 : 0;
            hi = other_half ? DISPLAY_WIDTH : DISPLAY_WIDTH / 2;
            res.is_read = 1'b1;
            if (int'(column_offset) < hi - lo) begin
               if (rotated)
                  res.read_byte = mirror_byte(
                     frame_copy[7 - int'(page_index)][hi - 1 - int'(column_offset)]);
               else
                  res.read_byte = frame_copy[page_index][lo + int'(column_offset)];
            end
         end
         KIND_CLEAR: begin
            foreach (frame_copy[p, x]) frame_copy[p][x] = '0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      panel_out_t got, want;
      if (reset) begin
         foreach (frame_copy[p, x]) frame_copy[p][x] = '0;
         due_results.delete();
         mismatches = 0;
         lit_reads  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_byte = rsp_mon.read_byte;
            got.is_read   = rsp_mon.is_read;
            if (due_results.size() == 0) begin
               $error("unexpected result item: read_byte %02h is_read %0b",
                      got.read_byte, got.is_read);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (got.read_byte !== want.read_byte) begin
                  $error("read_byte: expected %02h, got %02h", want.read_byte, got.read_byte);
                  mismatches++;
               end
               if (got.is_read !== want.is_read) begin
                  $error("is_read: expected %0b, got %0b", want.is_read, got.is_read);
                  mismatches++;
               end
               if (want.is_read && want.read_byte != 0) lit_reads++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            draw_or_read(req_mon.kind, req_mon.col, req_mon.row, req_mon.length,
                         req_mon.glyph_byte, req_mon.half, req_mon.rotated,
                         req_mon.page_index, req_mon.column_offset, want);
            due_results.push_back(want);
         end
      end
      pending = due_results.size();
   end

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pfb_pkg::*;

   // Cycles with no handshake on either channel before the run is abandoned.
   // Worst honest gap: a full clear behind the long receiver hold-off, or the
   // clear sweep after reset.
   localparam int STUCK_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 225;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 100;

   logic clock;
   logic reset;

   pfb_req_if req ();
   pfb_rsp_if rsp ();

   int fail_total;
   int outstanding;
   int lit_reads;

   // knobs for the traffic shape, changed between phases
   int sender_idle_pct;
   int recv_stall_pct;
   int rx_hold;

   int kind_count [8];
   logic [7:0] last_col;
   logic [7:0] last_row;
   int stuck_cycles;

   page_framebuffer_draw_engine_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   pfb_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .mismatches (fail_total),
      .pending    (outstanding),
      .lit_reads  (lit_reads)
   );

   always #10 clock = ~clock;

   // Receiver: a long hold-off, when asked for, wins over the random stalls.
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp.ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results outstanding",
                  stuck_cycles, outstanding);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offers one command item; entered and left just after a falling edge.
   // Valid stays high from one item to the next unless an idle gap is drawn.
   task automatic issue(
      input logic [2:0] kind,
      input logic [7:0] col,
      input logic [7:0] row,
      input logic [7:0] length,
      input logic [7:0] glyph_byte,
      input logic       half,
      input logic       rotated,
      input logic [2:0] page_index,
      input logic [6:0] column_offset
   );
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.kind          <= kind;
      req.col           <= col;
      req.row           <= row;
      req.length        <= length;
      req.glyph_byte    <= glyph_byte;
      req.half          <= half;
      req.rotated       <= rotated;
      req.page_index    <= page_index;
      req.column_offset <= column_offset;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      kind_count[kind]++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // Random command. Half the reads aim at the pixel last drawn so that they
   // come back with lit bits; line lengths are mostly short to keep the run fast.
   task automatic random_command();
      logic [2:0] k;
      logic [7:0] c, r, len, g;
      logic       h, rot;
      logic [2:0] pg;
      logic [6:0] off;
      int pick, tc, tr, in_second;
      pick = $urandom_range(0, 999);
      c    = 8'($urandom);
      r    = 8'($urandom);
      g    = 8'($urandom);
      h    = 1'($urandom);
      rot  = 1'($urandom);
      pg   = 3'($urandom);
      off  = 7'($urandom);
      len  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
      if (pick < 150)      k = KIND_HLINE;
      else if (pick < 300) k = KIND_VLINE;
      else if (pick < 500) k = KIND_GLYPH;
      else if (pick < 970) k = KIND_READ;
      else if (pick < 985) k = KIND_CLEAR;
      else                 k = 3'($urandom_range(5, 7));
      if (k == KIND_READ && $urandom_range(0, 1) == 1) begin
         tc = int'(last_col) % DISPLAY_WIDTH;
         tr = int'(last_row) % DISPLAY_HEIGHT;
         in_second = (tc >= HALF_FIRST);
         if (!rot) begin
            h   = 1'(in_second);
            off = 7'(tc - in_second * HALF_FIRST);
            pg  = 3'(tr / 8);
         end else begin
            // a rotated read looks at the other half, mirrored
            h   = 1'(!in_second);
            off = 7'((in_second ? DISPLAY_WIDTH : HALF_FIRST) - 1 - tc);
            pg  = 3'(7 - tr / 8);
         end
      end
      if (k == KIND_HLINE || k == KIND_VLINE || k == KIND_GLYPH) begin
         last_col = c;
         last_row = r;
      end
      issue(k, c, r, len, g, h, rot, pg, off);
   endtask

   initial begin
      int idle_of  [4];
      int stall_of [4];
      idle_of  = '{0, 54, 0, 6};
      stall_of = '{0, 0, 54, 6};
      clock = 1'b0;
      reset = 1'b1;
      rx_hold = 0;
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      last_col = '0;
      last_row = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      req.valid = 1'b0;
      req.kind = KIND_HLINE;
      req.col = '0;
      req.row = '0;
      req.length = '0;
      req.glyph_byte = '0;
      req.half = 1'b0;
      req.rotated = 1'b0;
      req.page_index = '0;
      req.column_offset = '0;
      rsp.ready = 1'b0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, no idling ----
      // empty store reads back zero, unrotated and rotated
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 3'd7, 7'd127);
      // zero-length lines draw nothing
      issue(KIND_HLINE, 8'd5, 8'd3, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_VLINE, 8'd5, 8'd3, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      // col + length overflows 8 bits: must clip at the right edge, not wrap
      issue(KIND_HLINE, 8'd200, 8'd9, 8'd100, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      // col and row above the panel size fold back (255 -> col 15, row 63)
      issue(KIND_HLINE, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      // vertical line clipped at the bottom, and one over the full height
      issue(KIND_VLINE, 8'd239, 8'd60, 8'd255, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_VLINE, 8'd0, 8'd0, 8'd64, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      // glyph columns: aligned, split across two pages, spill off the bottom
      issue(KIND_GLYPH, 8'd119, 8'd0, 8'd0, 8'hA5, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_GLYPH, 8'd120, 8'd13, 8'd0, 8'hFF, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_GLYPH, 8'd255, 8'd63, 8'd0, 8'hFF, 1'b0, 1'b0, 3'd0, 7'd0);
      // reads: both halves, both orientations, last column of a half
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd119);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 3'd1, 7'd0);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 3'd7, 7'd119);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 3'd0, 7'd0);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 3'd7, 7'd0);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 3'd6, 7'd119);
      // offset past the half width reads zero, still flagged as a read
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd120);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 3'd0, 7'd127);
      // unused kinds change nothing and answer zero
      issue(3'd5, 8'd1, 8'd1, 8'd9, 8'hFF, 1'b1, 1'b1, 3'd7, 7'd3);
      issue(3'd6, 8'd1, 8'd1, 8'd9, 8'hFF, 1'b0, 1'b0, 3'd0, 7'd3);
      issue(3'd7, 8'd1, 8'd1, 8'd9, 8'hFF, 1'b1, 1'b0, 3'd3, 7'd3);
      // clear, then the earlier lit column must read empty
      issue(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd0);
      issue(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 3'd0, 7'd119);

      // ---- long receiver hold-off while the sender keeps offering ----
      @(posedge clock);
      rx_hold = LONG_HOLD;
      @(negedge clock);
      for (int i = 0; i < 8; i++) random_command();

      // ---- random phases, drained in between ----
      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         sender_idle_pct = idle_of[ph];
         recv_stall_pct  = stall_of[ph];
         for (int i = 0; i < PHASE_ITEMS; i++) random_command();
      end

      wait_drained();
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("items: %0d hline, %0d vline, %0d glyph, %0d read (%0d lit), %0d clear, %0d unused",
               kind_count[KIND_HLINE], kind_count[KIND_VLINE], kind_count[KIND_GLYPH],
               kind_count[KIND_READ], lit_reads, kind_count[KIND_CLEAR],
               kind_count[5] + kind_count[6] + kind_count[7]);
      $display("traffic: four idle/stall mixes, one %0d-cycle receiver hold-off", LONG_HOLD);
      if (fail_total == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/pfb_pkg.sv
hdl/pfb_req_if.sv
hdl/pfb_rsp_if.sv
hdl/pfb_ram.sv
hdl/page_framebuffer_draw_engine_core.sv
hdl/pfb_checker.sv
verif/pfb_checker.sv
verif/tb_top.sv
